@@ hdl/assert_macros.svh @@
// Assertion macros used by the checker file of the project.
// Depends on nothing; the including module supplies aclk and aresetn.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge of aclk outside reset.
`define AST_CHECK(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Check a property on every rising edge of aclk, reset cycles included.
`define AST_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) (prop)) else $error(msg);

`endif

@@ hdl/msseq_pkg.sv @@
// Package of the motor starter sequencer: codes, widths and shared structs.
// Used by every module of the block; depends on nothing.
package msseq_pkg;

    localparam int COUNT_BITS = 16;
    localparam int CFG_W      = 16;
    localparam int PADDR_W    = 4;

    typedef enum logic [2:0] {
        MODE_OFF      = 3'd0,
        MODE_ACT_LOW  = 3'd1,
        MODE_ON_LOW   = 3'd2,
        MODE_ACT_HIGH = 3'd3,
        MODE_ON_HIGH  = 3'd4,
        MODE_RESET    = 3'd5
    } mode_t;

    typedef enum logic [2:0] {
        ACT_TICK         = 3'd0,
        ACT_ACTIVATE_LOW = 3'd1,
        ACT_ACTIVATE_HI  = 3'd2,
        ACT_RESET_FAULT  = 3'd3,
        ACT_OFF          = 3'd4,
        ACT_SET_FREERUN  = 3'd5
    } action_t;

    // Steps of the activation and fault-reset procedures
    localparam logic [2:0] STEP_ENTRY        = 3'd0;
    localparam logic [2:0] STEP_CLEAR_WAIT   = 3'd1;
    localparam logic [2:0] STEP_FREERUN_WAIT = 3'd2;
    localparam logic [2:0] STEP_RUN          = 3'd3;
    localparam logic [2:0] STEP_SETTLE       = 3'd4;
    localparam logic [2:0] STEP_SPEED_WAIT   = 3'd5;

    // Register indexes on the configuration port
    localparam logic [1:0] REG_SETTLE       = 2'd0;
    localparam logic [1:0] REG_LOW_TIMEOUT  = 2'd1;
    localparam logic [1:0] REG_HIGH_TIMEOUT = 2'd2;

    localparam logic [CFG_W-1:0] SETTLE_RESET  = 16'd7;
    localparam logic [CFG_W-1:0] TIMEOUT_RESET = 16'd334;

    typedef struct packed {
        logic [CFG_W-1:0] settle_ticks;
        logic [CFG_W-1:0] low_timeout_ticks;
        logic [CFG_W-1:0] high_timeout_ticks;
    } cfg_t;

    typedef struct packed {
        logic [2:0] action;
        logic       fault_line;
        logic       speed_ok_line;
        logic       freerun_value;
    } item_t;

    typedef struct packed {
        logic [2:0] step;
        logic [2:0] mode;
        logic       high_speed_out;
        logic       freerun_out;
        logic       run_out;
    } result_t;

endpackage

@@ hdl/msseq_regs.sv @@
// Configuration registers of the motor starter sequencer behind an APB-style port.
// Depends on msseq_pkg.
module msseq_regs (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [msseq_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    output msseq_pkg::cfg_t               cfg
);
    import msseq_pkg::*;

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign wr_en   = psel & penable & pwrite & pready;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (reg_idx)
                REG_SETTLE:       cfg_next.settle_ticks       = pwdata[CFG_W-1:0];
                REG_LOW_TIMEOUT:  cfg_next.low_timeout_ticks  = pwdata[CFG_W-1:0];
                REG_HIGH_TIMEOUT: cfg_next.high_timeout_ticks = pwdata[CFG_W-1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.settle_ticks       <= SETTLE_RESET;
            cfg_reg.low_timeout_ticks  <= TIMEOUT_RESET;
            cfg_reg.high_timeout_ticks <= TIMEOUT_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // read back, unused address reads zero
    always_comb begin
        case (reg_idx)
            REG_SETTLE:       prdata = {16'd0, cfg_reg.settle_ticks};
            REG_LOW_TIMEOUT:  prdata = {16'd0, cfg_reg.low_timeout_ticks};
            REG_HIGH_TIMEOUT: prdata = {16'd0, cfg_reg.high_timeout_ticks};
            default:          prdata = 32'd0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

@@ hdl/msseq_core.sv @@
// Input register and sequencing state machine of the motor starter sequencer.
// Depends on msseq_pkg.
module msseq_core (
    input  logic                aclk,
    input  logic                aresetn,
    input  msseq_pkg::cfg_t     cfg,
    input  logic                item_valid,
    output logic                item_ready,
    input  msseq_pkg::item_t    item,
    output logic                res_push,
    input  logic                res_space,
    output msseq_pkg::result_t  res
);
    import msseq_pkg::*;

    localparam logic [COUNT_BITS-1:0] ONE = COUNT_BITS'(1);

    // input word register
    logic                  in_valid_reg;
    logic                  in_valid_next;
    item_t                 in_reg;
    logic                  advance;

    // sequencer state
    mode_t                 mode_reg,    mode_next;
    logic [2:0]            step_reg,    step_next;
    logic [COUNT_BITS-1:0] wait_reg,    wait_next;
    logic                  run_reg,     run_next;
    logic                  freerun_reg, freerun_next;
    logic                  speed_reg,   speed_next;

    logic                  kill;
    logic                  high;
    logic [COUNT_BITS-1:0] wait_dec;
    logic [COUNT_BITS-1:0] settle_load;
    logic [COUNT_BITS-1:0] timeout_load;

    assign advance       = in_valid_reg & res_space;
    assign item_ready    = ~in_valid_reg | res_space;
    assign in_valid_next = (item_valid & item_ready) | (in_valid_reg & ~advance);

    assign high         = (mode_reg == MODE_ACT_HIGH);
    assign wait_dec     = wait_reg - ONE;
    assign settle_load  = COUNT_BITS'(cfg.settle_ticks);
    assign timeout_load = high ? COUNT_BITS'(cfg.high_timeout_ticks)
                               : COUNT_BITS'(cfg.low_timeout_ticks);

    // next state
    always_comb begin
        mode_next    = mode_reg;
        step_next    = step_reg;
        wait_next    = wait_reg;
        run_next     = run_reg;
        freerun_next = freerun_reg;
        speed_next   = speed_reg;
        kill         = 1'b0;

        case (action_t'(in_reg.action))
            ACT_TICK: begin
                case (mode_reg)
                    MODE_ACT_LOW, MODE_ACT_HIGH: begin
                        case (step_reg)
                            STEP_ENTRY: begin
                                freerun_next = 1'b0;
                                speed_next   = high;
                                if (!high || in_reg.fault_line) begin
                                    run_next = 1'b0;
                                end
                                if (in_reg.fault_line) begin
                                    wait_next = settle_load;
                                    step_next = STEP_CLEAR_WAIT;
                                end else begin
                                    step_next = STEP_RUN;
                                end
                            end
                            STEP_CLEAR_WAIT: begin
                                if (wait_reg != '0) begin
                                    wait_next = wait_dec;
                                end else begin
                                    freerun_next = 1'b1;
                                    wait_next    = settle_load;
                                    step_next    = STEP_FREERUN_WAIT;
                                end
                            end
                            STEP_FREERUN_WAIT: begin
                                if (wait_reg != '0) begin
                                    wait_next = wait_dec;
                                end else if (in_reg.fault_line) begin
                                    kill = 1'b1;
                                end else begin
                                    freerun_next = 1'b0;
                                    step_next    = STEP_RUN;
                                end
                            end
                            STEP_RUN: begin
                                run_next  = 1'b1;
                                wait_next = settle_load;
                                step_next = STEP_SETTLE;
                            end
                            STEP_SETTLE: begin
                                if (wait_reg != '0) begin
                                    wait_next = wait_dec;
                                end else begin
                                    wait_next = timeout_load;
                                    step_next = STEP_SPEED_WAIT;
                                end
                            end
                            STEP_SPEED_WAIT: begin
                                // zero count means no timeout
                                if (wait_reg != '0) begin
                                    wait_next = wait_dec;
                                end
                                if (wait_reg != '0 && wait_dec == '0) begin
                                    kill = 1'b1;
                                end else if (in_reg.fault_line) begin
                                    kill = 1'b1;
                                end else if (in_reg.speed_ok_line) begin
                                    step_next = STEP_ENTRY;
                                    mode_next = high ? MODE_ON_HIGH : MODE_ON_LOW;
                                end
                            end
                            default: ;
                        endcase
                    end
                    MODE_RESET: begin
                        case (step_reg)
                            STEP_ENTRY: begin
                                run_next     = 1'b0;
                                freerun_next = 1'b0;
                                wait_next    = settle_load;
                                step_next    = STEP_CLEAR_WAIT;
                            end
                            STEP_CLEAR_WAIT: begin
                                if (wait_reg != '0) begin
                                    wait_next = wait_dec;
                                end else begin
                                    freerun_next = 1'b1;
                                    wait_next    = settle_load;
                                    step_next    = STEP_FREERUN_WAIT;
                                end
                            end
                            STEP_FREERUN_WAIT: begin
                                if (wait_reg != '0) begin
                                    wait_next = wait_dec;
                                end else begin
                                    kill = 1'b1;
                                end
                            end
                            default: ;
                        endcase
                    end
                    MODE_ON_LOW, MODE_ON_HIGH: begin
                        kill = in_reg.fault_line;
                    end
                    default: ;
                endcase
            end
            ACT_ACTIVATE_LOW: begin
                if (mode_reg == MODE_OFF || mode_reg == MODE_RESET) begin
                    mode_next = MODE_ACT_LOW;
                    step_next = STEP_ENTRY;
                end
            end
            ACT_ACTIVATE_HI: begin
                if (mode_reg != MODE_ACT_HIGH && mode_reg != MODE_ON_HIGH) begin
                    mode_next = MODE_ACT_HIGH;
                    step_next = STEP_ENTRY;
                end
            end
            ACT_RESET_FAULT: begin
                if (mode_reg == MODE_OFF) begin
                    if (in_reg.fault_line) begin
                        mode_next = MODE_RESET;
                        step_next = STEP_ENTRY;
                    end else begin
                        kill = 1'b1;
                    end
                end
            end
            ACT_OFF: begin
                kill = 1'b1;
            end
            ACT_SET_FREERUN: begin
                freerun_next = in_reg.freerun_value;
            end
            default: ;
        endcase

        // turn off: speed select is kept
        if (kill) begin
            run_next     = 1'b0;
            freerun_next = 1'b0;
            mode_next    = MODE_OFF;
            wait_next    = '0;
            step_next    = STEP_ENTRY;
        end
    end

    // result word
    always_comb begin
        res.run_out        = run_next;
        res.freerun_out    = freerun_next;
        res.high_speed_out = speed_next;
        res.mode           = mode_next;
        res.step           = step_next;
    end

    assign res_push = advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            mode_reg     <= MODE_OFF;
            step_reg     <= STEP_ENTRY;
            wait_reg     <= '0;
            run_reg      <= 1'b0;
            freerun_reg  <= 1'b0;
            speed_reg    <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
            if (advance) begin
                mode_reg    <= mode_next;
                step_reg    <= step_next;
                wait_reg    <= wait_next;
                run_reg     <= run_next;
                freerun_reg <= freerun_next;
                speed_reg   <= speed_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (item_valid && item_ready) begin
            in_reg <= item;
        end
    end

endmodule

@@ hdl/msseq_outq.sv @@
// Two-word result queue of the motor starter sequencer, decoupling stalls.
// Depends on msseq_pkg.
module msseq_outq (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  msseq_pkg::result_t push_data,
    output logic               space,
    output logic               m_valid,
    input  logic               m_ready,
    output msseq_pkg::result_t m_data
);
    import msseq_pkg::*;

    result_t    mem [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg,  count_next;
    logic       pop;

    assign m_valid = (count_reg != 2'd0);
    assign space   = (count_reg != 2'd2);
    assign pop     = m_valid & m_ready;
    assign m_data  = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

@@ hdl/motor_starter_sequencer.sv @@
// Top level of the motor starter sequencer: stream ports, APB registers.
// Depends on msseq_pkg, msseq_regs, msseq_core and msseq_outq.
//
// Use: each input word carries an action in s_tuser (tick, activate low,
// activate high, reset fault, off, set free-run) and the sampled fault,
// speed-ok and free-run lines in s_tdata. Every word yields exactly one
// result word on m_: the run, free-run and high-speed drive levels after
// the action, with the current mode and procedure step.
// Path: a taken word is held in the input register, evaluated by the state
// machine and written to the result queue; m_tvalid shows it from there.
// Throughput: one word per cycle while the result queue has space, set by the
// combinational next-state logic between the input register and the result queue.
// Stall: the two-word result queue keeps taking words while the receiver
// holds m_tready low; once both slots and the input register are full,
// s_tready drops and the state machine holds.
// Reset (aresetn low at a clock edge): the starter is off, all drives low,
// queue empty, registers back to settle 7 and timeouts 334 ticks.
// Write registers only while no word is in flight.
module motor_starter_sequencer (
    input  logic                          aclk,
    input  logic                          aresetn,
    // s_tdata: [0] fault_line, [1] speed_ok_line, [2] freerun_value, [7:3] zero
    input  logic [7:0]                    s_tdata,
    // s_tuser: [2:0] action
    input  logic [2:0]                    s_tuser,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // m_tdata: [0] run_out, [1] freerun_out, [2] high_speed_out,
    //          [5:3] mode, [8:6] step, [15:9] zero
    output logic [15:0]                   m_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [msseq_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import msseq_pkg::*;

    cfg_t    cfg;
    item_t   item;
    result_t res;
    result_t q_data;
    logic    res_push;
    logic    res_space;

    // unpack the input word
    assign item.action        = s_tuser;
    assign item.fault_line    = s_tdata[0];
    assign item.speed_ok_line = s_tdata[1];
    assign item.freerun_value = s_tdata[2];

    msseq_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    msseq_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .item_valid (s_tvalid),
        .item_ready (s_tready),
        .item       (item),
        .res_push   (res_push),
        .res_space  (res_space),
        .res        (res)
    );

    msseq_outq u_outq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (res_push),
        .push_data (res),
        .space     (res_space),
        .m_valid   (m_tvalid),
        .m_ready   (m_tready),
        .m_data    (q_data)
    );

    // pack the result word, zero fill to 16 bits
    assign m_tdata = {7'd0, q_data};

endmodule

@@ hdl/msseq_checker.sv @@
// Port-level checker of the motor starter sequencer and its bind.
// Depends on assert_macros.svh, msseq_pkg and the top level's ports.
`include "assert_macros.svh"

module msseq_props (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic [15:0] m_tdata,
    input logic        m_tvalid,
    input logic        m_tready
);
    import msseq_pkg::*;

    // result word holds while the receiver stalls
    `AST_CHECK(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata),
               "result word changed under stall")

    // reset empties the queue and opens the input
    `AST_ALWAYS(a_reset_clear, !aresetn |=> !m_tvalid && s_tready,
                "reset left block busy")

    // off means no run drive and no step
    `AST_CHECK(a_off_idle,
               m_tvalid && m_tdata[5:3] == MODE_OFF |-> !m_tdata[0] && m_tdata[8:6] == STEP_ENTRY,
               "off with run or step set")

    // active high speed keeps run and high-speed select on
    `AST_CHECK(a_on_high,
               m_tvalid && m_tdata[5:3] == MODE_ON_HIGH |->
                   m_tdata[0] && m_tdata[2] && m_tdata[8:6] == STEP_ENTRY,
               "active high without run or speed")

endmodule

bind motor_starter_sequencer msseq_props u_msseq_props (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);
